// ----- rtl/core/indexed_min_heap_assert.svh -----
// assertion macros for the indexed min-heap checker
// no dependencies
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH
`define IMH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: lbl failed");
`define IMH_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: lbl failed");
`endif

// ----- rtl/core/imh_pkg.sv -----
// shared constants and types for the indexed min-heap
// no dependencies
package imh_pkg;
    localparam int CAPACITY     = 4096;
    localparam int ID_SPACE     = 4096;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 40;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int ID_W   = $clog2(ID_SPACE);
    localparam int CNT_W  = $clog2(CAPACITY) + 1;
    localparam int ENT_W  = KEY_BITS + ID_W + PAYLOAD_BITS;

    typedef logic [1:0] t_op;
    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_LOWER = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_EMPTY     = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_ABSENT    = 3'd3;
    localparam t_status ST_PRESENT   = 3'd4;
    localparam t_status ST_NOT_LOWER = 3'd5;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [ID_W-1:0]         id;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_entry;
endpackage

// ----- rtl/core/imh_ram.sv -----
// generic one-write one-read ram with registered read data
// depends on nothing
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/indexed_min_heap.sv -----
// indexed min-heap top level: request sequencer, heap, position and presence rams
// depends on imh_pkg and imh_ram
//
// channel | direction | fields
// request | in        | opcode item_id priority_req payload
// result  | out       | status out_id out_priority out_payload occupancy
//
// after reset a clearing pass over all 4096 ids zeroes the presence ram; stall stays high
// during it, and from the accepting edge until the result reaches the output register: push
// checks then sifts up by parent compares, lower-key checks the key then sifts up, pop sifts down
// a finished result waits in the output state while the output register is stalled
module indexed_min_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_item_id,
    input  logic [15:0] i_priority_req,
    input  logic [39:0] i_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [11:0] o_out_id,
    output logic [15:0] o_out_priority,
    output logic [39:0] o_out_payload,
    output logic [12:0] o_occupancy
);
    localparam int SW = imh_pkg::SLOT_W;
    localparam int IW = imh_pkg::ID_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CHK, S_LK_WT, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2,
        S_DN_CMP, S_DN_CMP2, S_POP_RD, S_POP_WT, S_OUT
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_clr;
    imh_pkg::t_op r_op;
    logic [imh_pkg::CNT_W-1:0] r_count;
    imh_pkg::t_entry r_cur, r_best;
    logic [SW-1:0] r_pos, r_bpos;
    imh_pkg::t_status r_st;
    imh_pkg::t_entry r_oent;

    logic h_we;
    logic [SW-1:0] h_wa, h_ra;
    imh_pkg::t_entry h_wd, h_rd;
    logic m_we;
    logic [IW-1:0] m_wa, m_ra;
    logic [SW-1:0] m_wd, m_rd;
    logic p_we;
    logic [IW-1:0] p_wa, p_ra;
    logic p_wd, p_rd;

    imh_ram #(.WIDTH(imh_pkg::ENT_W), .DEPTH(imh_pkg::CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));
    imh_ram #(.WIDTH(SW), .DEPTH(imh_pkg::ID_SPACE)) u_map (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));
    imh_ram #(.WIDTH(1), .DEPTH(imh_pkg::ID_SPACE)) u_pres (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));

    logic accept;
    logic push_ok;
    logic [SW-1:0] parent, lch, rch;
    logic [imh_pkg::CNT_W:0] lch_w;
    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign parent = (r_pos - SW'(1)) >> 1;
    assign lch_w  = {1'b0, r_pos, 1'b1};
    assign lch    = SW'(lch_w);
    assign rch    = lch + SW'(1);
    assign push_ok = !p_rd && (r_count < imh_pkg::CNT_W'(imh_pkg::CAPACITY));

    always_comb begin
        h_we = 1'b0; h_wa = r_pos; h_wd = r_cur; h_ra = r_pos;
        m_we = 1'b0; m_wa = r_cur.id; m_wd = r_pos; m_ra = i_item_id;
        p_we = 1'b0; p_wa = r_cur.id; p_wd = 1'b0; p_ra = i_item_id;
        case (r_state)
            S_CLR: begin
                p_we = 1'b1;
                p_wa = r_clr;
            end
            S_IDLE: h_ra = SW'(r_count - 1'b1);
            S_CHK: begin
                h_ra = m_rd;
                if (r_op == imh_pkg::OP_PUSH && push_ok) begin
                    p_we = 1'b1;
                    p_wd = 1'b1;
                end
            end
            S_POP_RD: h_ra = '0;
            S_POP_WT: begin
                p_we = 1'b1;
                p_wa = h_rd.id;
            end
            S_UP_RD: h_ra = parent;
            S_UP_CMP: begin
                if (r_pos != '0 && r_cur.key < h_rd.key) begin
                    h_we = 1'b1; h_wa = r_pos; h_wd = h_rd;
                    m_we = 1'b1; m_wa = h_rd.id; m_wd = r_pos;
                end else begin
                    h_we = 1'b1; m_we = 1'b1;
                end
            end
            S_DN_RD:  h_ra = lch;
            S_DN_RD2: h_ra = rch;
            S_DN_CMP2: begin
                h_we = 1'b1;
                if (r_bpos != r_pos) begin
                    h_wd = r_best; m_wa = r_best.id;
                end
                m_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_opcode;
                        r_oent <= '0;
                        r_cur <= '{i_priority_req, i_item_id, i_payload};
                        case (i_opcode)
                            imh_pkg::OP_PUSH, imh_pkg::OP_LOWER: begin
                                r_state <= S_CHK;
                            end
                            imh_pkg::OP_POP: begin
                                if (r_count == '0) begin
                                    r_st <= imh_pkg::ST_EMPTY;
                                    r_state <= S_OUT;
                                end else begin
                                    r_st <= imh_pkg::ST_OK;
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_POP_RD;
                                end
                            end
                            default: begin
                                r_st <= imh_pkg::ST_OK;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_op == imh_pkg::OP_PUSH) begin
                        if (p_rd) begin
                            r_st <= imh_pkg::ST_PRESENT;
                            r_state <= S_OUT;
                        end else if (!push_ok) begin
                            r_st <= imh_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_st <= imh_pkg::ST_OK;
                            r_pos <= SW'(r_count);
                            r_count <= r_count + 1'b1;
                            r_state <= S_UP_RD;
                        end
                    end else begin
                        if (!p_rd) begin
                            r_st <= imh_pkg::ST_ABSENT;
                            r_state <= S_OUT;
                        end else begin
                            r_st <= imh_pkg::ST_OK;
                            r_pos <= m_rd;
                            r_state <= S_LK_WT;
                        end
                    end
                end
                S_POP_RD: begin
                    r_cur <= h_rd;
                    r_pos <= '0;
                    r_state <= S_POP_WT;
                end
                S_POP_WT: begin
                    r_oent <= h_rd;
                    r_state <= (r_count == '0) ? S_OUT : S_DN_RD;
                end
                S_LK_WT: begin
                    if (r_cur.key >= h_rd.key) begin
                        r_st <= imh_pkg::ST_NOT_LOWER;
                        r_state <= S_OUT;
                    end else begin
                        r_cur <= '{r_cur.key, h_rd.id, h_rd.pay};
                        r_state <= S_UP_RD;
                    end
                end
                S_UP_RD: r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    if (r_pos != '0 && r_cur.key < h_rd.key) begin
                        r_pos <= parent;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DN_RD: begin
                    r_best <= r_cur;
                    r_bpos <= r_pos;
                    r_state <= S_DN_RD2;
                end
                S_DN_RD2: begin
                    if (lch_w < {1'b0, r_count} && r_cur.key > h_rd.key) begin
                        r_best <= h_rd;
                        r_bpos <= lch;
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (lch_w + 1'b1 < {1'b0, r_count}
                        && r_best.key > h_rd.key) begin
                        r_best <= h_rd;
                        r_bpos <= rch;
                    end
                    r_state <= S_DN_CMP2;
                end
                S_DN_CMP2: begin
                    if (r_bpos != r_pos) begin
                        r_pos <= r_bpos;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_status <= r_st;
                        o_out_id <= r_oent.id;
                        o_out_priority <= r_oent.key;
                        o_out_payload <= r_oent.pay;
                        o_occupancy <= r_count;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/core/imh_checker.sv -----
// port-level checker for the indexed min-heap, bound to the top level
// depends on indexed_min_heap_assert.svh and imh_pkg
`include "indexed_min_heap_assert.svh"
module imh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [11:0] o_out_id,
    input logic [12:0] o_occupancy
);
    `IMH_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `IMH_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= imh_pkg::ST_NOT_LOWER)
    `IMH_ASSERT_IMP(a_id_zero, i_clk, i_rst_n, o_valid && o_status != imh_pkg::ST_OK, o_out_id == '0)
    `IMH_ASSERT_IMP(a_occ_range, i_clk, i_rst_n, o_valid, o_occupancy <= 13'(imh_pkg::CAPACITY))
endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_out_id(o_out_id), .o_occupancy(o_occupancy));

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for indexed_min_heap: random and directed requests,
// an in-order heap predictor and a field-by-field check of every result
// depends on imh_pkg and the indexed_min_heap rtl
module testbench;
    localparam imh_pkg::t_op OP_UNUSED = 2'd3;

    typedef struct {
        imh_pkg::t_op op;
        logic [11:0]  id;
        logic [15:0]  key;
        logic [39:0]  pay;
    } t_request;

    typedef struct {
        imh_pkg::t_status status;
        logic [11:0]      id;
        logic [15:0]      key;
        logic [39:0]      pay;
        logic [12:0]      occ;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [11:0] i_item_id = '0;
    logic [15:0] i_priority_req = '0;
    logic [39:0] i_payload = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_out_id;
    logic [15:0] o_out_priority;
    logic [39:0] o_out_payload;
    logic [12:0] o_occupancy;

    t_request pending_requests[$];
    t_answer  heap_answers[$];
    int       outstanding = 0;
    int       errors = 0;
    bit       calm = 1'b0;

    logic [15:0] heap_key[imh_pkg::CAPACITY];
    logic [11:0] heap_id[imh_pkg::CAPACITY];
    logic [39:0] heap_pay[imh_pkg::CAPACITY];
    int          slot_of[imh_pkg::ID_SPACE];
    bit          present[imh_pkg::ID_SPACE];
    int          heap_count = 0;

    indexed_min_heap dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void swap_slots(int a, int b);
        logic [15:0] k;
        logic [11:0] d;
        logic [39:0] p;
        k = heap_key[a]; d = heap_id[a]; p = heap_pay[a];
        heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b]; heap_pay[a] = heap_pay[b];
        heap_key[b] = k; heap_id[b] = d; heap_pay[b] = p;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    function automatic void bubble_up(int s);
        while (s > 0 && heap_key[s] < heap_key[(s - 1) >> 1]) begin
            swap_slots(s, (s - 1) >> 1);
            s = (s - 1) >> 1;
        end
    endfunction

    function automatic void bubble_down(int s);
        int best;
        forever begin
            best = s;
            if (2 * s + 1 < heap_count && heap_key[best] > heap_key[2 * s + 1])
                best = 2 * s + 1;
            if (2 * s + 2 < heap_count && heap_key[best] > heap_key[2 * s + 2])
                best = 2 * s + 2;
            if (best == s)
                return;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic void predict_heap(t_request r);
        t_answer a;
        int      last;
        int      s;
        a = '{imh_pkg::ST_OK, '0, '0, '0, '0};
        case (r.op)
            imh_pkg::OP_PUSH: begin
                if (present[r.id]) begin
                    a.status = imh_pkg::ST_PRESENT;
                end else if (heap_count >= imh_pkg::CAPACITY) begin
                    a.status = imh_pkg::ST_FULL;
                end else begin
                    s = heap_count++;
                    heap_key[s] = r.key; heap_id[s] = r.id; heap_pay[s] = r.pay;
                    slot_of[r.id] = s;
                    present[r.id] = 1'b1;
                    bubble_up(s);
                end
            end
            imh_pkg::OP_POP: begin
                if (heap_count == 0) begin
                    a.status = imh_pkg::ST_EMPTY;
                end else begin
                    last = heap_count - 1;
                    a.id = heap_id[0]; a.key = heap_key[0]; a.pay = heap_pay[0];
                    present[a.id] = 1'b0;
                    if (last != 0) begin
                        heap_key[0] = heap_key[last];
                        heap_id[0] = heap_id[last];
                        heap_pay[0] = heap_pay[last];
                        slot_of[heap_id[0]] = 0;
                    end
                    heap_count = last;
                    bubble_down(0);
                end
            end
            imh_pkg::OP_LOWER: begin
                if (!present[r.id] || slot_of[r.id] >= heap_count) begin
                    a.status = imh_pkg::ST_ABSENT;
                end else if (r.key >= heap_key[slot_of[r.id]]) begin
                    a.status = imh_pkg::ST_NOT_LOWER;
                end else begin
                    heap_key[slot_of[r.id]] = r.key;
                    bubble_up(slot_of[r.id]);
                end
            end
            default: ;
        endcase
        a.occ = heap_count[12:0];
        heap_answers.push_back(a);
    endfunction

    task automatic queue_request(imh_pkg::t_op op, logic [11:0] id, logic [15:0] key,
                                 logic [39:0] pay);
        pending_requests.push_back('{op, id, key, pay});
        outstanding++;
    endtask

    task automatic wait_drain();
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [39:0] rand_pay();
        return 40'({$urandom, $urandom});
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_heap('{imh_pkg::t_op'(i_opcode), i_item_id, i_priority_req,
                               i_payload});
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
                    r = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= r.op;
                    i_item_id <= r.id;
                    i_priority_req <= r.key;
                    i_payload <= r.pay;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n) begin
            i_stall <= !calm && $urandom_range(99) < 7;
            if (o_valid && !i_stall) begin
                if (heap_answers.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    a = heap_answers.pop_front();
                    outstanding--;
                    if (o_status !== a.status) begin
                        $error("status exp %0d got %0d", a.status, o_status);
                        errors++;
                    end
                    if (o_out_id !== a.id) begin
                        $error("out_id exp %0d got %0d", a.id, o_out_id);
                        errors++;
                    end
                    if (o_out_priority !== a.key) begin
                        $error("out_priority exp %0d got %0d", a.key, o_out_priority);
                        errors++;
                    end
                    if (o_out_payload !== a.pay) begin
                        $error("out_payload exp %h got %h", a.pay, o_out_payload);
                        errors++;
                    end
                    if (o_occupancy !== a.occ) begin
                        $error("occupancy exp %0d got %0d", a.occ, o_occupancy);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int          live_ids[$];
        int          pick;
        logic [11:0] id;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_request(imh_pkg::OP_PUSH, 12'd0, 16'hffff, {40{1'b1}});
        queue_request(imh_pkg::OP_PUSH, 12'hfff, 16'h0000, 40'h0);
        queue_request(imh_pkg::OP_PUSH, 12'd0, 16'd3, 40'h1);
        queue_request(imh_pkg::OP_LOWER, 12'd7, 16'd1, 40'h0);
        queue_request(imh_pkg::OP_LOWER, 12'd0, 16'hffff, 40'h0);
        queue_request(imh_pkg::OP_LOWER, 12'd0, 16'd5, 40'h0);
        queue_request(imh_pkg::OP_PUSH, 12'd10, 16'd100, 40'haa);
        queue_request(imh_pkg::OP_PUSH, 12'd11, 16'd100, 40'hbb);
        queue_request(imh_pkg::OP_PUSH, 12'd12, 16'd100, 40'hcc);
        queue_request(imh_pkg::OP_PUSH, 12'd13, 16'd5, 40'hdd);
        queue_request(OP_UNUSED, 12'hfff, 16'hffff, {40{1'b1}});
        queue_request(imh_pkg::OP_LOWER, 12'd12, 16'd0, 40'h0);
        repeat (8) queue_request(imh_pkg::OP_POP, 12'd0, 16'd0, 40'h0);
        queue_request(imh_pkg::OP_LOWER, 12'd10, 16'd0, 40'h0);
        wait_drain();

        // random batches, a stretch of them with no idling
        for (int b = 0; b < 30; b++) begin
            calm = (b >= 10 && b < 16);
            live_ids.delete();
            for (int i = 0; i < imh_pkg::ID_SPACE; i++)
                if (present[i]) live_ids.push_back(i);
            repeat (50) begin
                pick = $urandom_range(99);
                if ($urandom_range(9) < 7) id = 12'($urandom_range(63));
                else id = 12'($urandom);
                if (pick < 45) begin
                    queue_request(imh_pkg::OP_PUSH, id,
                        $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom), rand_pay());
                    live_ids.push_back(int'(id));
                end else if (pick < 75) begin
                    queue_request(imh_pkg::OP_POP, id, 16'($urandom), rand_pay());
                end else if (pick < 95) begin
                    if (live_ids.size() != 0 && $urandom_range(9) < 8)
                        id = 12'(live_ids[$urandom_range(live_ids.size() - 1)]);
                    queue_request(imh_pkg::OP_LOWER, id,
                        $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom), rand_pay());
                end else begin
                    queue_request(OP_UNUSED, id, 16'($urandom), rand_pay());
                end
            end
            wait_drain();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        if (errors == 0 && heap_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
